/* hdl/ppp_pkg.sv */
// Shared constants, types and helpers for the polyline path position block.
package ppp_pkg;

    localparam int MaxPoints = 64;
    localparam int AddrW = $clog2(MaxPoints);
    localparam int CountW = $clog2(MaxPoints + 1);
    localparam int PointW = 96;
    localparam int SegW = 34;
    localparam int TotalW = 48;
    localparam logic [31:0] SpeedReset = 32'd65536;
    localparam logic [16:0] ProgressOne = 17'd65536;

    typedef enum logic [1:0] {
        ACT_CLEAR = 2'd0,
        ACT_APPEND = 2'd1,
        ACT_QUERY = 2'd2,
        ACT_NONE = 2'd3
    } action_t;

    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
    } point_t;

    // offset = a + sign(d) * ((|d| * f) >> 16), wrapped to 32 bits
    function automatic logic signed [31:0] lerp_add(
        input logic signed [31:0] a,
        input logic signed [32:0] d,
        input logic [48:0] prod);
        logic [32:0] off;
        logic [32:0] res;
        off = prod[48:16];
        if (d < 0)
            res = {a[31], a} - off;
        else
            res = {a[31], a} + off;
        return res[31:0];
    endfunction

endpackage

/* hdl/ppp_if.sv */
// Valid/ready channel interfaces for input and result items.
interface ppp_in_if;
    logic valid;
    logic ready;
    logic [1:0] action;
    logic signed [31:0] coord_x;
    logic signed [31:0] coord_y;
    logic signed [31:0] coord_z;
    logic [31:0] now_time;
    modport source (output valid, action, coord_x, coord_y, coord_z, now_time, input ready);
    modport sink (input valid, action, coord_x, coord_y, coord_z, now_time, output ready);
endinterface

interface ppp_out_if;
    logic valid;
    logic ready;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic complete;
    logic [16:0] progress;
    modport source (output valid, pos_x, pos_y, pos_z, complete, progress, input ready);
    modport sink (input valid, pos_x, pos_y, pos_z, complete, progress, output ready);
endinterface

/* hdl/ppp_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read.
module ppp_ram #(
    parameter int Width = 32,
    parameter int Depth = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(Depth)-1:0] waddr,
    input  logic [Width-1:0]         wdata,
    input  logic [$clog2(Depth)-1:0] raddr,
    output logic [Width-1:0]         rdata
);
    logic [Width-1:0] mem [Depth];

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        rdata <= mem[raddr];
    end
endmodule

/* hdl/ppp_div.sv */
// Restoring divider: 64-bit numerator by 48-bit divisor, one quotient bit a cycle.
module ppp_div (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [63:0] num,
    input  logic [47:0] den,
    output logic        done,
    output logic [63:0] quo
);
    logic [63:0] num_reg;
    logic [48:0] rem_reg;
    logic [47:0] den_reg;
    logic [6:0]  cnt_reg;
    logic        busy_reg;
    logic [48:0] shifted;
    logic [49:0] diff;

    assign shifted = {rem_reg[47:0], num_reg[63]};
    assign diff = {1'b0, shifted} - {2'b00, den_reg};
    assign quo = num_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            done <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg <= 7'd0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 7'd1;
                if (cnt_reg == 7'd63)
                begin
                    busy_reg <= 1'b0;
                    done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            num_reg <= num;
            den_reg <= den;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            if (!diff[49])
            begin
                rem_reg <= diff[48:0];
                num_reg <= {num_reg[62:0], 1'b1};
            end
            else
            begin
                rem_reg <= shifted;
                num_reg <= {num_reg[62:0], 1'b0};
            end
        end
    end
endmodule

/* hdl/ppp_sqrt.sv */
// Iterative integer square root of a 66-bit value, one root bit a cycle.
module ppp_sqrt (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [65:0] radicand,
    output logic        done,
    output logic [33:0] root
);
    logic [65:0] val_reg;
    logic [35:0] rem_reg;
    logic [33:0] root_reg;
    logic [5:0]  cnt_reg;
    logic        busy_reg;
    logic [35:0] rem_sh;
    logic [35:0] trial;

    assign rem_sh = {rem_reg[33:0], val_reg[65:64]};
    assign trial = {root_reg, 2'b01};
    assign root = root_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            done <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg <= 6'd0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 6'd1;
                // 33 bit pairs cover the whole radicand
                if (cnt_reg == 6'd32)
                begin
                    busy_reg <= 1'b0;
                    done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            val_reg <= radicand;
            rem_reg <= '0;
            root_reg <= '0;
        end
        else if (busy_reg)
        begin
            val_reg <= {val_reg[63:0], 2'b00};
            if (rem_sh >= trial)
            begin
                rem_reg <= rem_sh - trial;
                root_reg <= {root_reg[32:0], 1'b1};
            end
            else
            begin
                rem_reg <= rem_sh;
                root_reg <= {root_reg[32:0], 1'b0};
            end
        end
    end
endmodule

/* hdl/polyline_path_position_core.sv */
// Polyline path position: point and segment memories, clear, append and query sequencer.
// Append: store the point, then a square root (one root bit a cycle) of the summed squares.
// Query: a walk over the stored segments, then two divisions (fraction, then progress);
// empty or single-point paths skip the walk and the divisions.
// One item is worked on at a time; in.ready is high only in the idle state.
// Reset (asynchronous, active low) empties the path, drops the start latch, speed = 1.0.
module polyline_path_position_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [31:0] cfg_wdata,
    ppp_in_if.sink      in,
    ppp_out_if.source   out
);
    typedef enum logic [4:0] {
        S_IDLE, S_APP_RD, S_APP_SQ, S_APP_WAIT, S_APP_WR,
        S_Q_RD0, S_Q_ONE, S_Q_END, S_Q_WALK, S_Q_CHK, S_Q_PT1,
        S_Q_FDIV, S_Q_FWAIT, S_Q_MUL, S_Q_PDIV, S_Q_PWAIT, S_OUT
    } state_t;

    state_t state_reg;
    logic [31:0] speed_reg;
    logic [ppp_pkg::CountW-1:0] count_reg;
    logic [ppp_pkg::TotalW-1:0] total_reg;
    logic latched_reg;
    logic [31:0] start_ts_reg;
    ppp_pkg::point_t newpt_reg, pa_reg;
    logic [ppp_pkg::AddrW-1:0] idx_reg;
    logic [ppp_pkg::TotalW-1:0] dist_reg;
    logic [ppp_pkg::TotalW+1:0] acc_reg;
    logic [ppp_pkg::SegW-1:0] len_reg;
    logic [16:0] frac_reg;
    logic [65:0] sumsq_reg;
    logic [31:0] elapsed_reg;
    logic signed [32:0] dx_reg, dy_reg, dz_reg;
    logic [48:0] px_reg, py_reg, pz_reg;
    logic signed [31:0] ox_reg, oy_reg, oz_reg;
    logic odone_reg;
    logic [16:0] oprog_reg;
    logic ovalid_reg;

    logic pt_we;
    logic [ppp_pkg::AddrW-1:0] pt_waddr, pt_raddr, seg_raddr;
    ppp_pkg::point_t pt_rdata;
    logic [ppp_pkg::SegW-1:0] seg_rdata;
    logic seg_we;
    logic sq_start, sq_done;
    logic [33:0] sq_root;
    logic dv_start, dv_done;
    logic [63:0] dv_num, dv_quo;
    logic [47:0] dv_den;
    logic [32:0] mx, my, mz;
    logic [31:0] elapsed_c;
    logic [63:0] dist_prod;

    ppp_ram #(.Width(ppp_pkg::PointW), .Depth(ppp_pkg::MaxPoints)) u_pt_ram (
        .clk(clk), .we(pt_we), .waddr(pt_waddr), .wdata(newpt_reg),
        .raddr(pt_raddr), .rdata(pt_rdata));

    ppp_ram #(.Width(ppp_pkg::SegW), .Depth(ppp_pkg::MaxPoints)) u_seg_ram (
        .clk(clk), .we(seg_we), .waddr(pt_waddr), .wdata(sq_root),
        .raddr(seg_raddr), .rdata(seg_rdata));

    ppp_sqrt u_sqrt (.clk(clk), .rst_n(rst_n), .start(sq_start), .radicand(sumsq_reg),
        .done(sq_done), .root(sq_root));

    ppp_div u_div (.clk(clk), .rst_n(rst_n), .start(dv_start), .num(dv_num), .den(dv_den),
        .done(dv_done), .quo(dv_quo));

    assign in.ready = (state_reg == S_IDLE);
    assign out.valid = ovalid_reg;
    assign out.pos_x = ox_reg;
    assign out.pos_y = oy_reg;
    assign out.pos_z = oz_reg;
    assign out.complete = odone_reg;
    assign out.progress = oprog_reg;

    // write the point store only on an append, at the old count
    assign pt_we = (state_reg == S_APP_RD);
    assign pt_waddr = (state_reg == S_APP_RD) ? count_reg[ppp_pkg::AddrW-1:0]
                                               : idx_reg;
    assign seg_we = (state_reg == S_APP_WR);
    assign pt_raddr = idx_reg;
    assign seg_raddr = idx_reg;
    assign sq_start = (state_reg == S_APP_SQ);
    assign dv_start = (state_reg == S_Q_FDIV) || (state_reg == S_Q_PDIV);
    assign dv_num = (state_reg == S_Q_FDIV)
        ? {(dist_reg - acc_reg[ppp_pkg::TotalW-1:0]), 16'd0}
        : {dist_reg, 16'd0};
    assign dv_den = (state_reg == S_Q_FDIV) ? {14'd0, len_reg} : total_reg;

    assign mx = dx_reg < 0 ? 33'(-dx_reg) : 33'(dx_reg);
    assign my = dy_reg < 0 ? 33'(-dy_reg) : 33'(dy_reg);
    assign mz = dz_reg < 0 ? 33'(-dz_reg) : 33'(dz_reg);

    assign elapsed_c = (in.now_time >= (latched_reg ? start_ts_reg : in.now_time))
        ? in.now_time - (latched_reg ? start_ts_reg : in.now_time) : 32'd0;
    assign dist_prod = 64'(elapsed_reg) * 64'(speed_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            speed_reg <= ppp_pkg::SpeedReset;
        else if (cfg_we)
            speed_reg <= cfg_wdata;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            total_reg <= '0;
            latched_reg <= 1'b0;
            start_ts_reg <= '0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            case (state_reg)
                S_IDLE:
                begin
                    if (in.valid)
                    begin
                        newpt_reg <= '{in.coord_x, in.coord_y, in.coord_z};
                        case (ppp_pkg::action_t'(in.action))
                            ppp_pkg::ACT_CLEAR:
                            begin
                                count_reg <= '0;
                                total_reg <= '0;
                                latched_reg <= 1'b0;
                                start_ts_reg <= '0;
                            end
                            ppp_pkg::ACT_APPEND:
                            begin
                                if (count_reg < ppp_pkg::CountW'(ppp_pkg::MaxPoints))
                                begin
                                    idx_reg <= count_reg[ppp_pkg::AddrW-1:0] - 1'b1;
                                    state_reg <= S_APP_RD;
                                end
                            end
                            ppp_pkg::ACT_QUERY:
                            begin
                                idx_reg <= '0;
                                if (count_reg == '0)
                                begin
                                    ox_reg <= '0;
                                    oy_reg <= '0;
                                    oz_reg <= '0;
                                    odone_reg <= 1'b1;
                                    oprog_reg <= '0;
                                    ovalid_reg <= 1'b1;
                                    state_reg <= S_OUT;
                                end
                                else if (count_reg == ppp_pkg::CountW'(1))
                                begin
                                    // pass through S_Q_CHK while the read of point 0 completes
                                    odone_reg <= 1'b1;
                                    oprog_reg <= '0;
                                    frac_reg <= 17'h1FFFF;
                                    state_reg <= S_Q_CHK;
                                end
                                else
                                begin
                                    if (!latched_reg)
                                    begin
                                        latched_reg <= 1'b1;
                                        start_ts_reg <= in.now_time;
                                    end
                                    elapsed_reg <= elapsed_c;
                                    state_reg <= S_Q_RD0;
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                S_APP_RD:
                begin
                    // point written this cycle; previous point read arrives next
                    if (count_reg == '0)
                    begin
                        count_reg <= count_reg + 1'b1;
                        state_reg <= S_IDLE;
                    end
                    else
                        state_reg <= S_APP_WAIT;
                end
                S_APP_WAIT:
                begin
                    dx_reg <= 33'(newpt_reg.x) - 33'(pt_rdata.x);
                    dy_reg <= 33'(newpt_reg.y) - 33'(pt_rdata.y);
                    dz_reg <= 33'(newpt_reg.z) - 33'(pt_rdata.z);
                    state_reg <= S_Q_PT1;
                    sumsq_reg <= '0;
                    frac_reg <= '0;
                end
                S_Q_PT1:
                begin
                    // serves as the squaring step for an append
                    if (frac_reg == 17'd0)
                    begin
                        sumsq_reg <= 66'(mx) * 66'(mx);
                        frac_reg <= 17'd1;
                    end
                    else if (frac_reg == 17'd1)
                    begin
                        sumsq_reg <= sumsq_reg + 66'(my) * 66'(my);
                        frac_reg <= 17'd2;
                    end
                    else
                    begin
                        sumsq_reg <= sumsq_reg + 66'(mz) * 66'(mz);
                        state_reg <= S_APP_SQ;
                    end
                end
                S_APP_SQ:
                    state_reg <= S_APP_WR;
                S_APP_WR:
                begin
                    if (sq_done)
                    begin
                        total_reg <= total_reg + ppp_pkg::TotalW'(sq_root);
                        count_reg <= count_reg + 1'b1;
                        state_reg <= S_IDLE;
                    end
                end
                S_Q_ONE:
                begin
                    ox_reg <= pt_rdata.x;
                    oy_reg <= pt_rdata.y;
                    oz_reg <= pt_rdata.z;
                    ovalid_reg <= 1'b1;
                    state_reg <= S_OUT;
                end
                S_Q_RD0:
                begin
                    dist_reg <= dist_prod[63:16];
                    acc_reg <= '0;
                    state_reg <= S_Q_END;
                end
                S_Q_END:
                begin
                    if (dist_reg >= total_reg)
                    begin
                        idx_reg <= ppp_pkg::AddrW'(count_reg - 1'b1);
                        odone_reg <= 1'b1;
                        oprog_reg <= (total_reg != '0) ? ppp_pkg::ProgressOne : 17'd0;
                        state_reg <= S_Q_CHK;
                        frac_reg <= 17'h1FFFF;
                    end
                    else
                        state_reg <= S_Q_WALK;
                end
                S_Q_WALK:
                begin
                    // seg and point reads for idx_reg land now
                    if ((ppp_pkg::TotalW+2)'(dist_reg) <=
                        acc_reg + (ppp_pkg::TotalW+2)'(seg_rdata))
                    begin
                        len_reg <= seg_rdata;
                        pa_reg <= pt_rdata;
                        idx_reg <= idx_reg + 1'b1;
                        frac_reg <= '0;
                        state_reg <= S_Q_CHK;
                    end
                    else
                    begin
                        acc_reg <= acc_reg + (ppp_pkg::TotalW+2)'(seg_rdata);
                        idx_reg <= idx_reg + 1'b1;
                        state_reg <= S_Q_END;
                    end
                end
                S_Q_CHK:
                    state_reg <= frac_reg == 17'h1FFFF ? S_Q_ONE : S_Q_FDIV;
                S_Q_FDIV:
                begin
                    dx_reg <= 33'(pt_rdata.x) - 33'(pa_reg.x);
                    dy_reg <= 33'(pt_rdata.y) - 33'(pa_reg.y);
                    dz_reg <= 33'(pt_rdata.z) - 33'(pa_reg.z);
                    state_reg <= (len_reg == '0) ? S_Q_MUL : S_Q_FWAIT;
                end
                S_Q_FWAIT:
                begin
                    if (dv_done)
                    begin
                        frac_reg <= dv_quo[16:0];
                        state_reg <= S_Q_MUL;
                    end
                end
                S_Q_MUL:
                begin
                    px_reg <= 49'(mx) * 49'(frac_reg);
                    py_reg <= 49'(my) * 49'(frac_reg);
                    pz_reg <= 49'(mz) * 49'(frac_reg);
                    state_reg <= S_Q_PDIV;
                end
                S_Q_PDIV:
                begin
                    ox_reg <= ppp_pkg::lerp_add(pa_reg.x, dx_reg, px_reg);
                    oy_reg <= ppp_pkg::lerp_add(pa_reg.y, dy_reg, py_reg);
                    oz_reg <= ppp_pkg::lerp_add(pa_reg.z, dz_reg, pz_reg);
                    odone_reg <= 1'b0;
                    state_reg <= S_Q_PWAIT;
                end
                S_Q_PWAIT:
                begin
                    if (dv_done)
                    begin
                        oprog_reg <= dv_quo[16:0];
                        ovalid_reg <= 1'b1;
                        state_reg <= S_OUT;
                    end
                end
                S_OUT:
                begin
                    if (out.ready)
                    begin
                        ovalid_reg <= 1'b0;
                        state_reg <= S_IDLE;
                    end
                end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        out.valid |-> state_reg == S_OUT)
        else $error("result shown outside output state");
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= ppp_pkg::CountW'(ppp_pkg::MaxPoints))
        else $error("point count beyond capacity");
    assert property (@(posedge clk) disable iff (!rst_n)
        out.valid && out.complete == 1'b0 |-> out.progress <= ppp_pkg::ProgressOne)
        else $error("progress above one");
    assert property (@(posedge clk) disable iff (!rst_n)
        in.valid && in.ready |=> !out.valid || $past(in.action) == ppp_pkg::ACT_QUERY)
        else $error("result from a non-query item");
endmodule
